FILE: hw/rtl/sbrs_pkg.sv
// Shared types, codes and constants of the SCSI block request splitter.
`timescale 1ns / 1ps
`default_nettype none
package sbrs_pkg;

  // Default limits, handed to the top level parameters.
  localparam int unsigned MaxChunkDef    = 65535;
  localparam int unsigned MaxCommandsDef = 64;

  // Entries in the queue between the front and the back.
  localparam int unsigned QueueDepth = 4;

  // Configuration port geometry: five registers at 8-byte strides.
  localparam int unsigned CfgAddrW = 6;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [2:0] {
    REG_UNIT_PRESENT     = 3'd0,
    REG_UNIT_BLOCK_COUNT = 3'd1,
    REG_UNIT_NUMBER      = 3'd2,
    REG_BLOCK_BYTES      = 3'd3,
    REG_LONG_THRESHOLD   = 3'd4
  } reg_idx_e;

  localparam logic [31:0] BlockBytesRst    = 32'd512;
  localparam logic [31:0] LongThresholdRst = 32'h0FFF_FFFF;

  typedef enum logic [1:0] {
    ST_COMMAND = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_REJECT  = 2'd2,
    ST_TOOMANY = 2'd3
  } status_e;

  localparam logic [7:0] OpRead10  = 8'h28;
  localparam logic [7:0] OpRead16  = 8'h88;
  localparam logic [7:0] OpWrite10 = 8'h2A;
  localparam logic [7:0] OpWrite16 = 8'h8A;

  localparam logic [4:0] CdbLenShort = 5'd10;
  localparam logic [4:0] CdbLenLong  = 5'd16;

  typedef struct packed {
    logic        unit_present;
    logic [63:0] unit_block_count;
    logic [2:0]  unit_number;
    logic [31:0] block_bytes;
    logic [31:0] long_threshold;
  } cfg_t;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    logic        is_write;
    status_e     cls;
    logic [63:0] lba;
    logic [31:0] remaining;
  } req_t;

endpackage
`default_nettype wire

FILE: hw/rtl/sbrs_cfg.sv
// Configuration register file of the splitter behind an APB-style port.
`timescale 1ns / 1ps
`default_nettype none
module sbrs_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sbrs_pkg::CfgAddrW-1:0] paddr,
  input  wire logic [sbrs_pkg::CfgDataW-1:0] pwdata,
  output logic      [sbrs_pkg::CfgDataW-1:0] prdata,
  output logic                               pready,
  output sbrs_pkg::cfg_t                     cfg_o
);
  import sbrs_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[CfgAddrW-1:3]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_UNIT_PRESENT:     cfg_d.unit_present     = pwdata[0];
        REG_UNIT_BLOCK_COUNT: cfg_d.unit_block_count = pwdata;
        REG_UNIT_NUMBER:      cfg_d.unit_number      = pwdata[2:0];
        REG_BLOCK_BYTES:      cfg_d.block_bytes      = pwdata[31:0];
        REG_LONG_THRESHOLD:   cfg_d.long_threshold   = pwdata[31:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_UNIT_PRESENT:     prdata = {63'd0, cfg_q.unit_present};
      REG_UNIT_BLOCK_COUNT: prdata = cfg_q.unit_block_count;
      REG_UNIT_NUMBER:      prdata = {61'd0, cfg_q.unit_number};
      REG_BLOCK_BYTES:      prdata = {32'd0, cfg_q.block_bytes};
      REG_LONG_THRESHOLD:   prdata = {32'd0, cfg_q.long_threshold};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.unit_present     <= 1'b0;
      cfg_q.unit_block_count <= '0;
      cfg_q.unit_number      <= '0;
      cfg_q.block_bytes      <= BlockBytesRst;
      cfg_q.long_threshold   <= LongThresholdRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

FILE: hw/rtl/sbrs_front.sv
// Front end: takes requests, checks them against the unit and classifies them.
`timescale 1ns / 1ps
`default_nettype none
module sbrs_front #(
  parameter int unsigned MaxChunk    = sbrs_pkg::MaxChunkDef,
  parameter int unsigned MaxCommands = sbrs_pkg::MaxCommandsDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  sbrs_pkg::cfg_t      cfg_i,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire logic           op_i,
  input  wire logic [63:0]    start_lba_i,
  input  wire logic [31:0]    block_total_i,
  output logic                push_o,
  output sbrs_pkg::req_t      req_o,
  input  wire logic           full_i
);
  import sbrs_pkg::*;

  // Largest block count that still fits in the allowed number of commands.
  localparam logic [31:0] TooManyLimit = 32'(MaxCommands * MaxChunk);

  logic        s1_valid_q, s1_valid_d;
  logic        op_q;
  logic [63:0] lba_q;
  logic [31:0] rem_q;
  logic [64:0] end_q;
  logic        load;
  status_e     cls;

  assign push_o     = s1_valid_q && !full_i;
  assign load       = !s1_valid_q || push_o;
  assign in_stall_o = !load;
  assign s1_valid_d = load ? in_valid_i : s1_valid_q;

  // The end address is formed at acceptance so the range check is two compares.
  always_comb begin
    if (!cfg_i.unit_present) begin
      cls = ST_REJECT;
    end else if (rem_q == 32'd0) begin
      cls = ST_EMPTY;
    end else if (lba_q >= cfg_i.unit_block_count ||
                 end_q > {1'b0, cfg_i.unit_block_count}) begin
      cls = ST_REJECT;
    end else if (rem_q > TooManyLimit) begin
      cls = ST_TOOMANY;
    end else begin
      cls = ST_COMMAND;
    end
  end

  assign req_o = '{is_write: op_q, cls: cls, lba: lba_q, remaining: rem_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      op_q  <= op_i;
      lba_q <= start_lba_i;
      rem_q <= block_total_i;
      end_q <= {1'b0, start_lba_i} + {33'd0, block_total_i};
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sbrs_fifo.sv
// Short queue of classified requests between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module sbrs_fifo (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  sbrs_pkg::req_t wdata_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output sbrs_pkg::req_t rdata_o,
  output logic           empty_o
);
  import sbrs_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  req_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue fill count beyond its depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue popped while empty");

endmodule
`default_nettype wire

FILE: hw/rtl/sbrs_back.sv
// Back end: splits a classified request into commands and drives the result word.
`timescale 1ns / 1ps
`default_nettype none
module sbrs_back #(
  parameter int unsigned MaxChunk = sbrs_pkg::MaxChunkDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  sbrs_pkg::cfg_t   cfg_i,
  input  sbrs_pkg::req_t   req_i,
  input  wire logic        empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       result_status_o,
  output logic [4:0]       cdb_length_o,
  output logic [7:0]       cdb_opcode_o,
  output logic [7:0]       cdb_lun_byte_o,
  output logic [63:0]      cdb_lba_o,
  output logic [15:0]      cdb_blocks_o,
  output logic [47:0]      transfer_bytes_o,
  output logic             last_o
);
  import sbrs_pkg::*;

  localparam logic [31:0] ChunkMax = 32'(MaxChunk);

  // Working request.
  logic        busy_q, busy_d;
  logic        wr_q;
  status_e     cls_q;
  logic [63:0] lba_q;
  logic [31:0] rem_q;

  // Output register.
  logic        ov_q, ov_d;
  status_e     st_q;
  logic [4:0]  len_q;
  logic [7:0]  opc_q;
  logic [7:0]  lun_q;
  logic [63:0] olba_q;
  logic [15:0] blk_q;
  logic [47:0] bytes_q;
  logic        last_q;

  logic        emit, final_word, is_cmd, longf;
  logic [15:0] count;
  logic [32:0] lo_end;
  logic [7:0]  opc;
  logic [47:0] bytes;

  assign is_cmd     = (cls_q == ST_COMMAND);
  assign count      = (rem_q > ChunkMax) ? ChunkMax[15:0] : rem_q[15:0];
  assign final_word = !is_cmd || (rem_q <= ChunkMax);
  assign emit       = busy_q && (!ov_q || !out_stall_i);
  assign pop_o      = !empty_i && (!busy_q || (emit && final_word));
  assign busy_d     = pop_o ? 1'b1 : ((emit && final_word) ? 1'b0 : busy_q);
  assign ov_d       = emit ? 1'b1 : (ov_q && out_stall_i);

  // Long form when the address leaves the short range or the chunk crosses 2^32.
  assign lo_end = {1'b0, lba_q[31:0]} + {17'd0, count};
  assign longf  = (lba_q[31:0] > cfg_i.long_threshold) || (lba_q[63:32] != 32'd0) ||
                  (lo_end > 33'h1_0000_0000);
  assign opc    = wr_q ? (longf ? OpWrite16 : OpWrite10) : (longf ? OpRead16 : OpRead10);
  assign bytes  = {32'd0, count} * {16'd0, cfg_i.block_bytes};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      wr_q  <= req_i.is_write;
      cls_q <= req_i.cls;
      lba_q <= req_i.lba;
      rem_q <= req_i.remaining;
    end else if (emit) begin
      lba_q <= lba_q + {48'd0, count};
      rem_q <= rem_q - {16'd0, count};
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      st_q   <= cls_q;
      last_q <= final_word;
      if (is_cmd) begin
        len_q   <= longf ? CdbLenLong : CdbLenShort;
        opc_q   <= opc;
        lun_q   <= {cfg_i.unit_number, 5'd0};
        olba_q  <= lba_q;
        blk_q   <= count;
        bytes_q <= bytes;
      end else begin
        len_q   <= '0;
        opc_q   <= '0;
        lun_q   <= '0;
        olba_q  <= '0;
        blk_q   <= '0;
        bytes_q <= '0;
      end
    end
  end

  assign out_valid_o      = ov_q;
  assign result_status_o  = st_q;
  assign cdb_length_o     = len_q;
  assign cdb_opcode_o     = opc_q;
  assign cdb_lun_byte_o   = lun_q;
  assign cdb_lba_o        = olba_q;
  assign cdb_blocks_o     = blk_q;
  assign transfer_bytes_o = bytes_q;
  assign last_o           = last_q;

  a_status_word_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && st_q != ST_COMMAND) |-> last_q)
    else $error("status word without last mark");

  a_cmd_has_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && is_cmd) |-> (rem_q != 32'd0))
    else $error("command request with no blocks left");

endmodule
`default_nettype wire

FILE: hw/rtl/scsi_block_request_splitter.sv
// Top level of the SCSI block request splitter.
// Stages: front register, queue, back end working register, output register.
// Throughput: one word per cycle from the back end unless the output stalls, so
// single-chunk requests stream at one per cycle; the front takes one unless full.
// Reset: asynchronous and active low; it empties the queue and output register and
// loads the register defaults (unit absent, 512-byte blocks, threshold 0x0FFFFFFF).
`timescale 1ns / 1ps
`default_nettype none
module scsi_block_request_splitter #(
  parameter int unsigned MaxChunk    = sbrs_pkg::MaxChunkDef,
  parameter int unsigned MaxCommands = sbrs_pkg::MaxCommandsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration port.
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sbrs_pkg::CfgAddrW-1:0] paddr,
  input  wire logic [sbrs_pkg::CfgDataW-1:0] pwdata,
  output logic      [sbrs_pkg::CfgDataW-1:0] prdata,
  output logic                               pready,
  // Request channel.
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          op_i,
  input  wire logic [63:0]                   start_lba_i,
  input  wire logic [31:0]                   block_total_i,
  // Result channel.
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [1:0]                         result_status_o,
  output logic [4:0]                         cdb_length_o,
  output logic [7:0]                         cdb_opcode_o,
  output logic [7:0]                         cdb_lun_byte_o,
  output logic [63:0]                        cdb_lba_o,
  output logic [15:0]                        cdb_blocks_o,
  output logic [47:0]                        transfer_bytes_o,
  output logic                               last_o
);
  import sbrs_pkg::*;

  cfg_t cfg;
  req_t push_req, pop_req;
  logic push, pop, full, empty;

  // Register file; to be written only while the datapath is idle, which it does not enforce.
  sbrs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The front registers a request with its end address, then classifies it as a
  // command stream, an empty request, a reject or an oversize request.
  sbrs_front #(
    .MaxChunk    (MaxChunk),
    .MaxCommands (MaxCommands)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .start_lba_i   (start_lba_i),
    .block_total_i (block_total_i),
    .push_o        (push),
    .req_o         (push_req),
    .full_i        (full)
  );

  // The queue lets the front keep accepting while the back works through a
  // multi-chunk request or waits on a stalled output.
  sbrs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_req),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (pop_req),
    .empty_o (empty)
  );

  // The back steps through the chunks, one word per cycle unless the output stalls,
  // and pulls the next request in the same cycle as the current one's final word.
  sbrs_back #(
    .MaxChunk (MaxChunk)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .req_i            (pop_req),
    .empty_i          (empty),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_status_o  (result_status_o),
    .cdb_length_o     (cdb_length_o),
    .cdb_opcode_o     (cdb_opcode_o),
    .cdb_lun_byte_o   (cdb_lun_byte_o),
    .cdb_lba_o        (cdb_lba_o),
    .cdb_blocks_o     (cdb_blocks_o),
    .transfer_bytes_o (transfer_bytes_o),
    .last_o           (last_o)
  );

endmodule
`default_nettype wire
